// File: hw/rtl/tlsc_pkg.sv
// ----------------------------------------------------------------------------
// tlsc_pkg
// Shared types and codes for the three-level swap cache.
// ----------------------------------------------------------------------------
package tlsc_pkg;

    localparam int WORD_W = 32;
    localparam int HALF_W = 16;
    localparam int USE_W  = 16;
    localparam logic [USE_W-1:0] USE_MAX = '1;

    typedef enum logic [1:0] {
        ACT_READ = 2'd0,
        ACT_MARK = 2'd1,
        ACT_LOAD = 2'd2,
        ACT_NONE = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        HIT_L1  = 2'd0,
        HIT_L2  = 2'd1,
        HIT_L3  = 2'd2,
        HIT_MEM = 2'd3
    } t_hit;

    // Selector for the level a search or victim scan is run on.
    typedef enum logic [1:0] {
        LV_1 = 2'd0,
        LV_2 = 2'd1,
        LV_3 = 2'd2
    } t_level;

endpackage

// File: hw/rtl/tlsc_scan.sv
// ----------------------------------------------------------------------------
// tlsc_scan
// Walks the lines of one level, one line a cycle, and reports the first
// line matching a tag and the lowest-index line with the least use count.
// ----------------------------------------------------------------------------
module tlsc_scan
    import tlsc_pkg::*;
#(
    parameter int IDX_W = 8,
    parameter int TAG_W = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [IDX_W:0]   i_lines,
    input  logic [TAG_W-1:0] i_tag,
    // line presented this cycle (index r_cnt, driven back combinationally)
    output logic [IDX_W-1:0] o_idx,
    input  logic             i_valid,
    input  logic [TAG_W-1:0] i_line_tag,
    input  logic [USE_W-1:0] i_line_use,
    output logic             o_done,
    output logic             o_found,
    output logic [IDX_W-1:0] o_hit_idx,
    output logic [IDX_W-1:0] o_victim
);

    logic             r_busy;
    logic [IDX_W:0]   r_cnt;
    logic [USE_W-1:0] r_best_use;
    logic             r_found;
    logic [IDX_W-1:0] r_hit;
    logic [IDX_W-1:0] r_best;
    logic             r_done;

    logic             w_last;
    logic             w_better;

    assign o_idx    = r_cnt[IDX_W-1:0];
    assign w_last   = (r_cnt + 1'b1) == i_lines;
    assign w_better = (r_cnt == '0) || (i_line_use < r_best_use);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_cnt   <= '0;
                r_found <= 1'b0;
            end else if (r_busy) begin
                if (w_better) begin
                    r_best_use <= i_line_use;
                    r_best     <= r_cnt[IDX_W-1:0];
                end
                if (!r_found && i_valid && i_line_tag == i_tag) begin
                    r_found <= 1'b1;
                    r_hit   <= r_cnt[IDX_W-1:0];
                end
                if (w_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    assign o_done    = r_done;
    assign o_found   = r_found;
    assign o_hit_idx = r_hit;
    assign o_victim  = r_best;

endmodule

// File: hw/rtl/three_level_swap_cache_lfu.sv
// ----------------------------------------------------------------------------
// three_level_swap_cache_lfu
// Exclusive three-level fully associative cache with least-used replacement.
// ----------------------------------------------------------------------------
// One access at a time. Line metadata (tag, valid, dirty, use count) sits in
// small register files per level. Line data sits in one synchronous word
// memory per level plus the backing memory, and each of these is read through
// an output register. A read or mark access scans L1, then L2, then L3 until
// it finds the block, one line a cycle. For each level crossed, it then scans
// the level above for its victim and swaps the two lines word by word, reading
// and then writing each word, four words a line. A miss also scans L3 for its
// victim, writes that victim back when it is dirty, and fills the line with
// four words. The input is stalled while an access is in progress. A finished
// result waits in the output register without holding up the next transfer,
// but an access cannot finish while that register holds a stalled result.
// ----------------------------------------------------------------------------
module three_level_swap_cache_lfu
    import tlsc_pkg::*;
#(
    parameter int FIRST_LINES   = 4,
    parameter int SECOND_LINES  = 8,
    parameter int THIRD_LINES   = 16,
    parameter int MEMORY_BLOCKS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_block_address,
    input  logic [1:0]  i_word_index,
    input  logic [15:0] i_load_value,
    input  logic [15:0] i_mark_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_word_value,
    output logic [15:0] o_word_mark,
    output logic [1:0]  o_hit_level,
    output logic        o_mark_written
);

    localparam int I1 = (FIRST_LINES  > 1) ? $clog2(FIRST_LINES)  : 1;
    localparam int I2 = (SECOND_LINES > 1) ? $clog2(SECOND_LINES) : 1;
    localparam int I3 = (THIRD_LINES  > 1) ? $clog2(THIRD_LINES)  : 1;
    localparam int IM = (I1 > I2) ? ((I1 > I3) ? I1 : I3) : ((I2 > I3) ? I2 : I3);
    localparam int BW = (MEMORY_BLOCKS > 1) ? $clog2(MEMORY_BLOCKS) : 1;
    localparam int TW = BW;

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_LOAD   = 13'b0000000000010,
        S_SCAN   = 13'b0000000000100,
        S_WSCAN  = 13'b0000000001000,
        S_VSCAN  = 13'b0000000010000,
        S_VWAIT  = 13'b0000000100000,
        S_WBRD   = 13'b0000001000000,
        S_WBWR   = 13'b0000010000000,
        S_FILRD  = 13'b0000100000000,
        S_FILWR  = 13'b0001000000000,
        S_SWRD   = 13'b0010000000000,
        S_SWWR   = 13'b0100000000000,
        S_FIN    = 13'b1000000000000
    } t_state;

    t_state r_state;

    // metadata register files
    logic [TW-1:0]    r_tag1 [FIRST_LINES];
    logic [TW-1:0]    r_tag2 [SECOND_LINES];
    logic [TW-1:0]    r_tag3 [THIRD_LINES];
    logic [FIRST_LINES-1:0]  r_val1, r_dty1;
    logic [SECOND_LINES-1:0] r_val2, r_dty2;
    logic [THIRD_LINES-1:0]  r_val3, r_dty3;
    logic [USE_W-1:0] r_use1 [FIRST_LINES];
    logic [USE_W-1:0] r_use2 [SECOND_LINES];
    logic [USE_W-1:0] r_use3 [THIRD_LINES];

    // word memories
    logic [WORD_W-1:0] m1 [FIRST_LINES*4];
    logic [WORD_W-1:0] m2 [SECOND_LINES*4];
    logic [WORD_W-1:0] m3 [THIRD_LINES*4];
    logic [WORD_W-1:0] mb [MEMORY_BLOCKS*4];

    logic [WORD_W-1:0] r_q1, r_q2, r_q3, r_qb;
    logic [I1+1:0] w_a1;
    logic [I2+1:0] w_a2;
    logic [I3+1:0] w_a3;
    logic [BW+1:0] w_ab;

    // access registers
    logic [1:0]    r_act;
    logic [BW-1:0] r_blk;
    logic [1:0]    r_wi;
    logic [15:0]   r_ld, r_md;
    t_level        r_lv;       // level being scanned / upper level of a swap
    t_hit          r_hit;
    logic [IM-1:0] r_pos;      // line of the block at the lower level
    logic [IM-1:0] r_vic;      // victim line at the upper level
    logic [1:0]    r_w;
    logic [WORD_W-1:0] r_wa, r_wb;

    // output register
    logic        r_ov;
    logic [15:0] r_ovl, r_omk;
    logic [1:0]  r_ohl;
    logic        r_omw;

    // block number reduced modulo the memory size, as a constant table
    logic [BW-1:0] w_blk_mod [256];
    for (genvar g = 0; g < 256; g++) begin : g_blk_mod
        assign w_blk_mod[g] = BW'(g % MEMORY_BLOCKS);
    end

    // scan unit
    logic          w_start;
    logic [IM:0]   w_lines;
    logic [IM-1:0] w_sidx, w_shit, w_svic;
    logic          w_sval, w_sdone, w_sfound;
    logic [TW-1:0] w_stag;
    logic [USE_W-1:0] w_suse;

    tlsc_scan #(.IDX_W(IM), .TAG_W(TW)) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_lines    (w_lines),
        .i_tag      (r_blk),
        .o_idx      (w_sidx),
        .i_valid    (w_sval),
        .i_line_tag (w_stag),
        .i_line_use (w_suse),
        .o_done     (w_sdone),
        .o_found    (w_sfound),
        .o_hit_idx  (w_shit),
        .o_victim   (w_svic)
    );

    always_comb begin
        w_lines = '0;
        w_sval  = 1'b0;
        w_stag  = '0;
        w_suse  = '0;
        case (r_lv)
            LV_1: begin
                w_lines = (IM+1)'(FIRST_LINES);
                w_sval  = r_val1[w_sidx[I1-1:0]];
                w_stag  = r_tag1[w_sidx[I1-1:0]];
                w_suse  = r_use1[w_sidx[I1-1:0]];
            end
            LV_2: begin
                w_lines = (IM+1)'(SECOND_LINES);
                w_sval  = r_val2[w_sidx[I2-1:0]];
                w_stag  = r_tag2[w_sidx[I2-1:0]];
                w_suse  = r_use2[w_sidx[I2-1:0]];
            end
            default: begin
                w_lines = (IM+1)'(THIRD_LINES);
                w_sval  = r_val3[w_sidx[I3-1:0]];
                w_stag  = r_tag3[w_sidx[I3-1:0]];
                w_suse  = r_use3[w_sidx[I3-1:0]];
            end
        endcase
    end

    logic w_in_xfer, w_out_free;
    assign w_out_free = !r_ov || !i_stall;
    assign o_stall    = (r_state != S_IDLE);
    assign w_in_xfer  = i_valid && !o_stall;
    assign w_start    = (r_state == S_IDLE && w_in_xfer && i_action != ACT_LOAD
                         && i_action != ACT_NONE)
                        || (r_state == S_WSCAN && w_sdone && !w_sfound && r_lv != LV_3)
                        || (r_state == S_VSCAN);

    // memory addresses: upper level (r_lv) at r_vic, lower level at r_pos
    always_comb begin
        w_a1 = {r_vic[I1-1:0], r_w};
        w_a2 = (r_lv == LV_1) ? {r_pos[I2-1:0], r_w} : {r_vic[I2-1:0], r_w};
        w_a3 = {r_pos[I3-1:0], r_w};
        if (r_state == S_FIN) w_a1 = {r_vic[I1-1:0], r_wi};
        w_ab = (r_state == S_WBWR) ? {r_tag3[r_pos[I3-1:0]], r_w} : {r_blk, r_w};
    end

    // upper and lower data of the current swap
    logic [WORD_W-1:0] w_up, w_lo;
    assign w_up = (r_lv == LV_1) ? r_q1 : r_q2;
    assign w_lo = (r_lv == LV_1) ? r_q2 : r_q3;

    logic [WORD_W-1:0] w_word;
    logic              w_mwr;
    logic              w_fin_go;
    assign w_word = r_q1;
    assign w_mwr  = (r_act == ACT_MARK) && (w_word[31:16] == '0);
    // result leaves this cycle; for reads r_q1 is only valid once r_w has been set in FIN
    assign w_fin_go = (r_state == S_FIN) && w_out_free
                      && !(r_w == 2'd0 && r_act != ACT_LOAD && r_act != ACT_NONE);

    always_ff @(posedge i_clk) begin
        r_q1 <= m1[w_a1];
        r_q2 <= m2[w_a2];
        r_q3 <= m3[w_a3];
        r_qb <= mb[w_ab];
        if (r_state == S_LOAD) mb[{r_blk, r_wi}] <= {16'h0, r_ld};
        if (r_state == S_WBWR) mb[w_ab] <= r_q3;
        if (r_state == S_FILWR) m3[w_a3] <= r_qb;
        if (r_state == S_SWWR) begin
            if (r_lv == LV_1) begin
                m1[w_a1] <= w_lo;
                m2[w_a2] <= w_up;
            end else begin
                m2[w_a2] <= w_lo;
                m3[w_a3] <= w_up;
            end
        end
        if (w_fin_go && w_mwr) m1[w_a1] <= {r_md, w_word[15:0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_val1 <= '0; r_dty1 <= '0;
            r_val2 <= '0; r_dty2 <= '0;
            r_val3 <= '0; r_dty3 <= '0;
            for (int k = 0; k < FIRST_LINES; k++)  r_use1[k] <= '0;
            for (int k = 0; k < SECOND_LINES; k++) r_use2[k] <= '0;
            for (int k = 0; k < THIRD_LINES; k++)  r_use3[k] <= '0;
            r_ov <= 1'b0;
        end else begin
            if (w_fin_go) r_ov <= 1'b1;
            else if (r_ov && !i_stall) r_ov <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_act <= i_action;
                        r_blk <= w_blk_mod[i_block_address];
                        r_wi  <= i_word_index;
                        r_ld  <= i_load_value;
                        r_md  <= i_mark_data;
                        r_lv  <= LV_1;
                        r_w   <= '0;
                        if (i_action == ACT_LOAD) r_state <= S_LOAD;
                        else if (i_action == ACT_NONE) r_state <= S_FIN;
                        else r_state <= S_SCAN;
                    end
                end
                S_LOAD: r_state <= S_FIN;
                S_SCAN: r_state <= S_WSCAN;
                S_WSCAN: begin
                    if (w_sdone) begin
                        if (w_sfound) begin
                            r_pos <= w_shit;
                            r_hit <= t_hit'(r_lv);
                            if (r_lv == LV_1) begin
                                r_vic   <= w_shit;
                                r_state <= S_FIN;
                            end else begin
                                r_lv    <= t_level'(r_lv - 2'd1);
                                r_state <= S_VSCAN;
                            end
                        end else if (r_lv == LV_3) begin
                            r_hit   <= HIT_MEM;
                            r_state <= S_VSCAN;
                        end else begin
                            r_lv <= t_level'(r_lv + 2'd1);
                        end
                    end
                end
                S_VSCAN: r_state <= S_VWAIT;
                S_VWAIT: begin
                    if (w_sdone) begin
                        r_w <= '0;
                        if (r_hit == HIT_MEM && r_lv == LV_3) begin
                            r_pos <= w_svic;
                            if (r_val3[w_svic[I3-1:0]] && r_dty3[w_svic[I3-1:0]])
                                r_state <= S_WBRD;
                            else
                                r_state <= S_FILRD;
                        end else begin
                            r_vic   <= w_svic;
                            r_state <= S_SWRD;
                        end
                    end
                end
                S_WBRD: r_state <= S_WBWR;
                S_WBWR: begin
                    r_w <= r_w + 2'd1;
                    r_state <= (r_w == 2'd3) ? S_FILRD : S_WBRD;
                end
                S_FILRD: r_state <= S_FILWR;
                S_FILWR: begin
                    r_w <= r_w + 2'd1;
                    if (r_w == 2'd3) begin
                        r_tag3[r_pos[I3-1:0]] <= r_blk;
                        r_val3[r_pos[I3-1:0]] <= 1'b1;
                        r_dty3[r_pos[I3-1:0]] <= 1'b0;
                        r_use3[r_pos[I3-1:0]] <= '0;
                        r_lv    <= LV_2;
                        r_state <= S_VSCAN;
                    end else begin
                        r_state <= S_FILRD;
                    end
                end
                S_SWRD: r_state <= S_SWWR;
                S_SWWR: begin
                    r_w <= r_w + 2'd1;
                    if (r_w == 2'd3) begin
                        if (r_lv == LV_1) begin
                            r_tag1[r_vic[I1-1:0]] <= r_tag2[r_pos[I2-1:0]];
                            r_tag2[r_pos[I2-1:0]] <= r_tag1[r_vic[I1-1:0]];
                            r_use1[r_vic[I1-1:0]] <= r_use2[r_pos[I2-1:0]];
                            r_use2[r_pos[I2-1:0]] <= r_use1[r_vic[I1-1:0]];
                            r_val1[r_vic[I1-1:0]] <= r_val2[r_pos[I2-1:0]];
                            r_val2[r_pos[I2-1:0]] <= r_val1[r_vic[I1-1:0]];
                            r_dty1[r_vic[I1-1:0]] <= r_dty2[r_pos[I2-1:0]];
                            r_dty2[r_pos[I2-1:0]] <= r_dty1[r_vic[I1-1:0]];
                            r_state <= S_FIN;
                        end else begin
                            r_tag2[r_vic[I2-1:0]] <= r_tag3[r_pos[I3-1:0]];
                            r_tag3[r_pos[I3-1:0]] <= r_tag2[r_vic[I2-1:0]];
                            r_use2[r_vic[I2-1:0]] <= r_use3[r_pos[I3-1:0]];
                            r_use3[r_pos[I3-1:0]] <= r_use2[r_vic[I2-1:0]];
                            r_val2[r_vic[I2-1:0]] <= r_val3[r_pos[I3-1:0]];
                            r_val3[r_pos[I3-1:0]] <= r_val2[r_vic[I2-1:0]];
                            r_dty2[r_vic[I2-1:0]] <= r_dty3[r_pos[I3-1:0]];
                            r_dty3[r_pos[I3-1:0]] <= r_dty2[r_vic[I2-1:0]];
                            // the block now sits at L2 line r_vic
                            r_pos   <= r_vic;
                            r_lv    <= LV_1;
                            r_state <= S_VSCAN;
                        end
                    end else begin
                        r_state <= S_SWRD;
                    end
                end
                S_FIN: begin
                    // for reads r_q1 is valid only from the cycle after entry; wait for it first
                    if (r_w == 2'd0 && r_act != ACT_LOAD && r_act != ACT_NONE) begin
                        r_w <= 2'd1;
                    end else if (w_out_free) begin
                        r_state <= S_IDLE;
                        if (r_act == ACT_LOAD || r_act == ACT_NONE) begin
                            r_ovl <= '0; r_omk <= '0; r_ohl <= '0; r_omw <= 1'b0;
                        end else begin
                            r_ovl <= w_word[15:0];
                            r_omk <= w_word[31:16];
                            r_ohl <= r_hit;
                            r_omw <= w_mwr && (r_md != '0);
                            if (r_use1[r_vic[I1-1:0]] != USE_MAX)
                                r_use1[r_vic[I1-1:0]] <= r_use1[r_vic[I1-1:0]] + 1'b1;
                            if (w_mwr) r_dty1[r_vic[I1-1:0]] <= 1'b1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid        = r_ov;
    assign o_word_value   = r_ovl;
    assign o_word_mark    = r_omk;
    assign o_hit_level    = r_ohl;
    assign o_mark_written = r_omw;

    a_one_hot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall) else $error("input taken while busy");
    a_mw_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_omw) |-> (r_omk == '0)) else $error("mark written over nonzero");
    a_fill_l3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILWR && r_w == 2'd3) |=> r_val3[r_pos[I3-1:0]])
        else $error("fill left line invalid");

endmodule

// File: sim/cache_checker.sv
// ----------------------------------------------------------------------------
// cache_checker
// Watches both channels of the three-level swap cache, predicts each result
// from its own copy of the hierarchy and compares it field by field.
// ----------------------------------------------------------------------------
module cache_checker
    import tlsc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_stall_in,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_block_address,
    input  logic [1:0]  i_word_index,
    input  logic [15:0] i_load_value,
    input  logic [15:0] i_mark_data,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [15:0] i_word_value,
    input  logic [15:0] i_word_mark,
    input  logic [1:0]  i_hit_level,
    input  logic        i_mark_written,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [15:0] value;
        logic [15:0] mark;
        t_hit        hit;
        logic        written;
    } t_access_result;

    localparam int LINES_MAX = 16;
    localparam int BLOCKS    = 256;

    int           level_lines [3] = '{4, 8, 16};
    logic [7:0]   line_tag    [3][LINES_MAX];
    logic         line_vld    [3][LINES_MAX];
    logic         line_dirty  [3][LINES_MAX];
    logic [15:0]  line_uses   [3][LINES_MAX];
    logic [31:0]  line_words  [3][LINES_MAX][4];
    logic [31:0]  backing     [BLOCKS*4];

    t_access_result expected_results[$];

    function automatic int find_line(int lv, logic [7:0] blk);
        for (int i = 0; i < level_lines[lv]; i++)
            if (line_vld[lv][i] && line_tag[lv][i] == blk) return i;
        return -1;
    endfunction

    // lowest index among the least-used lines
    function automatic int least_used(int lv);
        int best;
        best = 0;
        for (int i = 1; i < level_lines[lv]; i++)
            if (line_uses[lv][i] < line_uses[lv][best]) best = i;
        return best;
    endfunction

    function automatic void trade_lines(int la, int ia, int lb, int ib);
        logic [31:0] w;
        logic [7:0]  t;
        logic [15:0] u;
        logic        b;
        for (int k = 0; k < 4; k++) begin
            w = line_words[la][ia][k];
            line_words[la][ia][k] = line_words[lb][ib][k];
            line_words[lb][ib][k] = w;
        end
        t = line_tag[la][ia];   line_tag[la][ia] = line_tag[lb][ib];     line_tag[lb][ib] = t;
        u = line_uses[la][ia];  line_uses[la][ia] = line_uses[lb][ib];   line_uses[lb][ib] = u;
        b = line_vld[la][ia];   line_vld[la][ia] = line_vld[lb][ib];     line_vld[lb][ib] = b;
        b = line_dirty[la][ia]; line_dirty[la][ia] = line_dirty[lb][ib]; line_dirty[lb][ib] = b;
    endfunction

    function automatic t_access_result cache_access(t_action act, logic [7:0] blk,
                                                    logic [1:0] wi, logic [15:0] loadv,
                                                    logic [15:0] markd);
        t_access_result r;
        int pos, lv, v;
        logic [31:0] word;
        r = '0;
        r.hit = HIT_L1;
        if (act == ACT_LOAD) begin
            backing[{blk, wi}] = {16'h0, loadv};
            return r;
        end
        if (act == ACT_NONE) return r;
        pos = -1;
        for (lv = 0; lv < 3; lv++) begin
            pos = find_line(lv, blk);
            if (pos >= 0) break;
        end
        if (lv == 3) begin
            pos = least_used(2);
            if (line_vld[2][pos] && line_dirty[2][pos])
                for (int k = 0; k < 4; k++)
                    backing[{line_tag[2][pos], 2'(k)}] = line_words[2][pos][k];
            for (int k = 0; k < 4; k++) line_words[2][pos][k] = backing[{blk, 2'(k)}];
            line_tag[2][pos]   = blk;
            line_vld[2][pos]   = 1'b1;
            line_dirty[2][pos] = 1'b0;
            line_uses[2][pos]  = '0;
            r.hit = HIT_MEM;
            lv = 2;
        end else begin
            r.hit = t_hit'(lv);
        end
        while (lv > 0) begin
            v = least_used(lv - 1);
            trade_lines(lv, pos, lv - 1, v);
            pos = v;
            lv--;
        end
        if (line_uses[0][pos] != USE_MAX) line_uses[0][pos]++;
        word = line_words[0][pos][wi];
        r.value = word[15:0];
        r.mark  = word[31:16];
        if (act == ACT_MARK && word[31:16] == 16'h0) begin
            line_words[0][pos][wi] = {markd, word[15:0]};
            line_dirty[0][pos] = 1'b1;
            r.written = (markd != 16'h0);
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_access_result e;
        if (!i_rst_n) begin
            expected_results.delete();
            o_fail_count <= 0;
            o_pending    <= 0;
            for (int l = 0; l < 3; l++)
                for (int i = 0; i < LINES_MAX; i++) begin
                    line_tag[l][i]   = '0;
                    line_vld[l][i]   = 1'b0;
                    line_dirty[l][i] = 1'b0;
                    line_uses[l][i]  = '0;
                    for (int k = 0; k < 4; k++) line_words[l][i][k] = '0;
                end
            for (int a = 0; a < BLOCKS*4; a++) backing[a] = '0;
        end else begin
            if (i_valid && !i_stall_in)
                expected_results.insert(expected_results.size(),
                                        cache_access(t_action'(i_action), i_block_address,
                                                     i_word_index, i_load_value,
                                                     i_mark_data));
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result transfer with nothing expected", $time);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    e = expected_results.pop_front();
                    if (e.value !== i_word_value || e.mark !== i_word_mark ||
                        e.hit !== i_hit_level || e.written !== i_mark_written) begin
                        $display("%0t: mismatch expected value %h mark %h level %0d written %b",
                                 $time, e.value, e.mark, e.hit, e.written);
                        $display("%0t:          actual   value %h mark %h level %0d written %b",
                                 $time, i_word_value, i_word_mark, i_hit_level,
                                 i_mark_written);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            o_pending <= expected_results.size();
        end
    end

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the three-level swap cache: directed corner
// accesses, then random loads and accesses over a pool of loaded blocks,
// with bursty input and patterned output stalls.
// ----------------------------------------------------------------------------
module testbench;
    import tlsc_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_action = '0;
    logic [7:0]  i_block_address = '0;
    logic [1:0]  i_word_index = '0;
    logic [15:0] i_load_value = '0;
    logic [15:0] i_mark_data = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [15:0] o_word_value;
    logic [15:0] o_word_mark;
    logic [1:0]  o_hit_level;
    logic        o_mark_written;
    int          fail_count;
    int          pending;

    logic [3:0]  loaded_words [256];
    int          block_pool [48];

    three_level_swap_cache_lfu DUT (.*);

    cache_checker checker_inst (
        .i_clk, .i_rst_n, .i_valid, .i_stall_in(o_stall), .i_action, .i_block_address,
        .i_word_index, .i_load_value, .i_mark_data, .i_out_valid(o_valid),
        .i_out_stall(i_stall), .i_word_value(o_word_value), .i_word_mark(o_word_mark),
        .i_hit_level(o_hit_level), .i_mark_written(o_mark_written),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #8000000;
        $display("Verification failed");
        $finish;
    end

    // stall is looked at mid-cycle, so the transfer edge is known before it comes
    task automatic send(t_action act, logic [7:0] blk, logic [1:0] wi,
                        logic [15:0] loadv, logic [15:0] markd);
        i_valid         <= 1'b1;
        i_action        <= act;
        i_block_address <= blk;
        i_word_index    <= wi;
        i_load_value    <= loadv;
        i_mark_data     <= markd;
        if (act == ACT_LOAD) loaded_words[blk][wi] = 1'b1;
        @(negedge i_clk);
        while (o_stall) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic idle(int cycles);
        if (cycles > 0) begin
            i_valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic load_block(logic [7:0] blk, logic [15:0] base);
        for (int k = 0; k < 4; k++) send(ACT_LOAD, blk, 2'(k), base ^ 16'(k), 16'hFFFF);
    endtask

    // receiver: stall pattern in stretches, plus one long hold-off
    initial begin
        int cyc, mode, left;
        cyc = 0; mode = 0; left = 0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (left == 0) begin
                mode = $urandom_range(0, 2);
                left = $urandom_range(32, 200);
            end
            left--;
            if (cyc >= 6000 && cyc < 6500)
                i_stall <= 1'b1;
            else if (mode == 0)
                i_stall <= 1'b0;
            else
                i_stall <= ($urandom_range(0, 99) < (mode == 1 ? 30 : 70));
        end
    end

    initial begin
        int r, blk, burst, waited;
        for (int b = 0; b < 256; b++) loaded_words[b] = '0;
        for (int k = 0; k < 48; k++) block_pool[k] = $urandom_range(0, 255);
        block_pool[0] = 0;
        block_pool[1] = 255;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corners
        load_block(8'h00, 16'h0000);
        load_block(8'hFF, 16'hFFFF);
        send(ACT_READ, 8'h00, 2'd0, 16'h0, 16'h0);         // memory fill
        send(ACT_READ, 8'h00, 2'd1, 16'h0, 16'h0);         // first-level hit
        send(ACT_MARK, 8'h00, 2'd3, 16'h0, 16'hFFFF);      // mark over zero
        send(ACT_MARK, 8'h00, 2'd3, 16'h0, 16'h1234);      // mark already set
        send(ACT_MARK, 8'hFF, 2'd1, 16'h0, 16'h0000);      // zero over zero: dirty only
        send(ACT_READ, 8'hFF, 2'd3, 16'h0, 16'h0);
        send(ACT_NONE, 8'hFF, 2'd3, 16'hFFFF, 16'hFFFF);   // no-op action
        send(ACT_LOAD, 8'h00, 2'd3, 16'hA5A5, 16'hFFFF);   // cached copy not updated
        send(ACT_READ, 8'h00, 2'd3, 16'h0, 16'h0);
        idle(5);

        waited = 0;
        for (int n = 0; n < 1200; ) begin
            burst = $urandom_range(1, 20);
            for (int j = 0; j < burst && n < 1200; j++, n++) begin
                r = $urandom_range(0, 99);
                blk = block_pool[$urandom_range(0, 47)];
                if (r < 3)
                    send(ACT_NONE, 8'($urandom), 2'($urandom), 16'($urandom), 16'($urandom));
                else if (r < 8)
                    send(ACT_LOAD, 8'($urandom), 2'($urandom), 16'($urandom), 16'($urandom));
                else if (r < 22 || loaded_words[blk] != 4'hF)
                    send(ACT_LOAD, 8'(blk), 2'($urandom),
                         ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom),
                         16'($urandom));
                else if (r < 60)
                    send(ACT_READ, 8'(blk), 2'($urandom), 16'($urandom), 16'($urandom));
                else
                    send(ACT_MARK, 8'(blk), 2'($urandom), 16'($urandom),
                         ($urandom_range(0, 9) == 0) ? 16'h0 : 16'($urandom));
            end
            if (n >= 800 && waited == 0) begin
                // drain completely before carrying on
                drain();
                waited = 1;
            end
            idle(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12));
        end

        drain();
        repeat (200) @(posedge i_clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
